[rtl/utf8xv_pkg.sv]
// Package for the UTF-8 / XML 1.0 character validator.
// Holds the decoder state type, the code point limits and the XML Char check.
// Used by utf8xv_dec and utf8_xml_char_validator_core.
package utf8xv_pkg;

    localparam int CodeWidth = 21;

    // Code point limits of the XML 1.0 Char production.
    localparam logic [CodeWidth-1:0] CpTab       = 21'h00_0009;
    localparam logic [CodeWidth-1:0] CpLf        = 21'h00_000A;
    localparam logic [CodeWidth-1:0] CpCr        = 21'h00_000D;
    localparam logic [CodeWidth-1:0] CpSpace     = 21'h00_0020;
    localparam logic [CodeWidth-1:0] CpBmpLoHi   = 21'h00_D7FF;
    localparam logic [CodeWidth-1:0] CpBmpHiLo   = 21'h00_E000;
    localparam logic [CodeWidth-1:0] CpBmpHiHi   = 21'h00_FFFD;
    localparam logic [CodeWidth-1:0] CpSuppLo    = 21'h01_0000;
    localparam logic [CodeWidth-1:0] CpSuppHi    = 21'h10_FFFF;

    // Lead byte prefixes, compared against the top bits of the byte.
    localparam logic [2:0] Lead2Prefix = 3'b110;
    localparam logic [3:0] Lead3Prefix = 4'b1110;
    localparam logic [4:0] Lead4Prefix = 5'b11110;
    localparam logic [1:0] ContPrefix  = 2'b10;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]           pending;
        logic [CodeWidth-1:0] accum;
        logic                 failed;
    } t_dec_state;

    // True when the code point is an XML 1.0 Char.
    function automatic logic is_xml_char(input logic [CodeWidth-1:0] cp);
        logic ok;
        ok = (cp == CpTab) || (cp == CpLf) || (cp == CpCr)
          || ((cp >= CpSpace)   && (cp <= CpBmpLoHi))
          || ((cp >= CpBmpHiLo) && (cp <= CpBmpHiHi))
          || ((cp >= CpSuppLo)  && (cp <= CpSuppHi));
        return ok;
    endfunction

endpackage

[rtl/utf8_xml_char_validator_core.sv]
// Streaming UTF-8 decoder that checks a text against the XML 1.0 Char set.
// Top level: input register, decoder state and verdict register; uses utf8xv_pkg
// and utf8xv_dec.

// The block takes one byte of text per request and sustains one request per
// clock cycle. Each request is captured in an input register, folded into the
// decoder state on the next cycle by a single pass of shallow compare-and-shift
// logic, and, on the byte flagged as last, one verdict is written to the output
// register, so a verdict passes through both the input register and the output
// register, and it waits while an earlier verdict is still stalled at the output.
// Bytes that are not last produce no result. Lead bytes of one to four bytes
// are decoded, continuations must be 10xxxxxx, and every code point must be
// tab, LF, CR, 20-D7FF, E000-FFFD or 10000-10FFFF; overlong forms pass. A
// failure sticks until the last byte, and a sequence cut off by the last byte
// fails. After each verdict the decoder returns to its reset state. The input
// side stalls only while a last byte waits for the output register to free up.
module utf8_xml_char_validator_core
    import utf8xv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_text_ok
);

    logic       r_in_valid;
    logic [7:0] r_text_byte;
    logic       r_is_last;
    t_dec_state r_state;
    t_dec_state n_state;
    logic       r_out_valid;
    logic       r_text_ok;

    logic w_accept;
    logic w_out_free;
    logic w_consume;
    logic w_verdict;

    // Handshake: a held byte moves on unless it is last and the verdict slot is full.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_consume  = r_in_valid && (!r_is_last || w_out_free);
    assign o_stall    = r_in_valid && !w_consume;
    assign w_accept   = i_valid && !o_stall;

    utf8xv_dec u_dec (
        .i_state     (r_state),
        .i_text_byte (r_text_byte),
        .o_state     (n_state)
    );

    assign w_verdict = !n_state.failed && (n_state.pending == 2'd0);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_consume);
        end
        if (w_accept) begin
            r_text_byte <= i_text_byte;
            r_is_last   <= i_is_last;
        end
    end

    // Decoder state; cleared after the last byte of each text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_consume) begin
            if (r_is_last) begin
                r_state <= '0;
            end else begin
                r_state <= n_state;
            end
        end
    end

    // Verdict register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && r_is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_consume && r_is_last) begin
            r_text_ok <= w_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_text_ok = r_text_ok;

    // A failure persists across the bytes of the same text.
    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && !r_is_last && r_state.failed) |=> r_state.failed)
        else $error("failure flag cleared in mid-text");

    // Every consumed last byte yields a verdict on the next cycle.
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_is_last) |=> o_valid)
        else $error("last byte consumed without a verdict");

    // The decoder starts every text from its reset state.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_is_last) |=> (r_state.pending == 2'd0) && !r_state.failed)
        else $error("decoder state not cleared after a verdict");

    // The input side only stalls with a last byte held behind a blocked verdict.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_is_last && r_out_valid && i_stall))
        else $error("input stalled without a blocked verdict");

endmodule

[rtl/utf8xv_dec.sv]
// Next-state logic of the validator: folds one text byte into the decoder state.
// Purely combinational; depends on utf8xv_pkg for the state type and checks.
module utf8xv_dec
    import utf8xv_pkg::*;
(
    input  t_dec_state i_state,
    input  logic [7:0] i_text_byte,
    output t_dec_state o_state
);

    logic [CodeWidth-1:0] w_shifted;

    // Continuation payload appended below the bits gathered so far.
    assign w_shifted = {i_state.accum[CodeWidth-7:0], i_text_byte[5:0]};

    always_comb begin
        o_state = i_state;
        if (i_state.failed) begin
            // Once failed, bytes are ignored until the end of the text.
            o_state = i_state;
        end else if (i_state.pending == 2'd0) begin
            // A lead byte is expected.
            if (i_text_byte[7] == 1'b0) begin
                if (!is_xml_char({{(CodeWidth-7){1'b0}}, i_text_byte[6:0]})) begin
                    o_state.failed = 1'b1;
                end
            end else if (i_text_byte[7:5] == Lead2Prefix) begin
                o_state.accum   = {{(CodeWidth-5){1'b0}}, i_text_byte[4:0]};
                o_state.pending = 2'd1;
            end else if (i_text_byte[7:4] == Lead3Prefix) begin
                o_state.accum   = {{(CodeWidth-4){1'b0}}, i_text_byte[3:0]};
                o_state.pending = 2'd2;
            end else if (i_text_byte[7:3] == Lead4Prefix) begin
                o_state.accum   = {{(CodeWidth-3){1'b0}}, i_text_byte[2:0]};
                o_state.pending = 2'd3;
            end else begin
                o_state.failed = 1'b1;
            end
        end else if (i_text_byte[7:6] != ContPrefix) begin
            // A continuation byte was expected and something else arrived.
            o_state.failed = 1'b1;
        end else begin
            o_state.accum   = w_shifted;
            o_state.pending = i_state.pending - 2'd1;
            if ((i_state.pending == 2'd1) && !is_xml_char(w_shifted)) begin
                o_state.failed = 1'b1;
            end
        end
    end

endmodule
